// ----- hw/rtl/pes_pkg.sv -----
// Package for the palette expand pixel scaler: field widths, register
// indexes, reset values and the color packing function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pes_pkg;

    localparam int ADDR_W        = 22;
    localparam int COLOR_W       = 32;
    localparam int LEVEL_W       = 8;
    localparam int INDEX_W       = 8;
    localparam int GROUP_W       = 32;
    localparam int SCALE_W       = 2;
    localparam int STRIDE_W      = 13;
    localparam int SHIFT_W       = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 13;
    localparam int PALETTE_ENTRIES = 256;
    localparam int PIXELS_PER_GROUP = 4;

    localparam int DEF_SOURCE_WIDTH  = 320;
    localparam int DEF_SOURCE_HEIGHT = 200;

    localparam logic [SCALE_W-1:0]  RST_SCALE  = 2'd1;
    localparam logic [STRIDE_W-1:0] RST_STRIDE = 13'd320;
    localparam logic [SHIFT_W-1:0]  RST_RED    = 5'd16;
    localparam logic [SHIFT_W-1:0]  RST_GREEN  = 5'd8;
    localparam logic [SHIFT_W-1:0]  RST_BLUE   = 5'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE   = 3'd4;

    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_PIXELS  = 1'b1;

    localparam logic [LEVEL_W-1:0] BYTE_MASK = 8'hff;

    // Bits shifted past the top of the word are dropped.
    function automatic logic [COLOR_W-1:0] place_level(
        input logic [LEVEL_W-1:0] level,
        input logic [SHIFT_W-1:0] shift
    );
        logic [COLOR_W-1:0] wide;
        wide = {{(COLOR_W-LEVEL_W){1'b0}}, level & BYTE_MASK};
        return wide << shift;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pes_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read before write on a shared address.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/palette_expand_pixel_scaler.sv -----
// Top level of the palette expand pixel scaler: palette, write sequencer,
// address generation and output register. Uses pes_pkg and pes_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes palette writes
//   (i_command = 0) and four-pixel groups (i_command = 1). A palette write
//   is stored at the transfer and causes no output. A pixel group causes
//   4 * s * s output transfers, s = scale_factor (0 acts as 1), in order:
//   pixel by pixel, rows top to bottom, columns left to right.
//   Output channel (o_out_valid / i_out_ready) carries one frame-buffer
//   write per transfer; o_last_of_item marks the last write of a group.
//   The first write of a group passes the sequencer, the read stage and the
//   output register. Throughput: one write per cycle while the output is
//   not stalled. The next item is taken in the cycle the last write of the
//   current group is issued, so groups follow with no gap.
//   Configuration: i_cfg_we writes register i_cfg_index; write only while idle.
//   Reset: counters go to the top-left corner, registers take their reset
//   values, and unwritten palette entries read as zero (a valid bit each).
//   Stall: o_out_valid high with i_out_ready low holds the pipeline; an idle
//   sequencer takes one group, but no item while a group has writes to issue.
`timescale 1ns / 1ps
`default_nettype none

module palette_expand_pixel_scaler #(
    parameter int SOURCE_WIDTH  = pes_pkg::DEF_SOURCE_WIDTH,
    parameter int SOURCE_HEIGHT = pes_pkg::DEF_SOURCE_HEIGHT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [pes_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [pes_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_command,
    input  wire logic [pes_pkg::INDEX_W-1:0]       i_entry_index,
    input  wire logic [pes_pkg::LEVEL_W-1:0]       i_red_level,
    input  wire logic [pes_pkg::LEVEL_W-1:0]       i_green_level,
    input  wire logic [pes_pkg::LEVEL_W-1:0]       i_blue_level,
    input  wire logic [pes_pkg::GROUP_W-1:0]       i_pixel_group,
    // output channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [pes_pkg::ADDR_W-1:0]        o_write_address,
    output logic      [pes_pkg::COLOR_W-1:0]       o_write_color,
    output logic                                   o_last_of_item
);

    localparam int ADDR_W   = pes_pkg::ADDR_W;
    localparam int COLOR_W  = pes_pkg::COLOR_W;
    localparam int INDEX_W  = pes_pkg::INDEX_W;
    localparam int SCALE_W  = pes_pkg::SCALE_W;
    localparam int STRIDE_W = pes_pkg::STRIDE_W;
    localparam int SHIFT_W  = pes_pkg::SHIFT_W;
    localparam int ENTRIES  = pes_pkg::PALETTE_ENTRIES;
    localparam int PIX_N    = pes_pkg::PIXELS_PER_GROUP;
    localparam int K_W      = $clog2(PIX_N);

    localparam int GROUPS   = (SOURCE_WIDTH / PIX_N) < 1 ? 1 : (SOURCE_WIDTH / PIX_N);
    localparam int GW       = GROUPS > 1 ? $clog2(GROUPS) : 1;
    localparam int RW       = SOURCE_HEIGHT > 1 ? $clog2(SOURCE_HEIGHT) : 1;
    localparam int CW       = GW + K_W + SCALE_W;   // col * scale
    localparam int SW_W     = STRIDE_W + SCALE_W;   // scale * stride

    localparam logic [GW-1:0] LAST_GROUP = GW'(GROUPS - 1);
    localparam logic [RW-1:0] LAST_ROW   = RW'(SOURCE_HEIGHT - 1);
    localparam logic [K_W-1:0] LAST_K    = K_W'(PIX_N - 1);

    // ---------------- configuration registers ----------------
    logic [SCALE_W-1:0]  r_scale;
    logic [STRIDE_W-1:0] r_stride;
    logic [SHIFT_W-1:0]  r_red_shift, r_green_shift, r_blue_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale       <= pes_pkg::RST_SCALE;
            r_stride      <= pes_pkg::RST_STRIDE;
            r_red_shift   <= pes_pkg::RST_RED;
            r_green_shift <= pes_pkg::RST_GREEN;
            r_blue_shift  <= pes_pkg::RST_BLUE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pes_pkg::CFG_SCALE:  r_scale       <= i_cfg_data[SCALE_W-1:0];
                pes_pkg::CFG_STRIDE: r_stride      <= i_cfg_data[STRIDE_W-1:0];
                pes_pkg::CFG_RED:    r_red_shift   <= i_cfg_data[SHIFT_W-1:0];
                pes_pkg::CFG_GREEN:  r_green_shift <= i_cfg_data[SHIFT_W-1:0];
                pes_pkg::CFG_BLUE:   r_blue_shift  <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [SCALE_W-1:0] scale_eff;
    logic [SCALE_W-1:0] scale_max;
    assign scale_eff = (r_scale == '0) ? SCALE_W'(1) : r_scale;
    assign scale_max = scale_eff - SCALE_W'(1);

    // ---------------- handshake ----------------
    logic adv;          // pipeline moves
    logic gen_last;     // sequencer issues final write of the group
    logic in_xfer;
    logic pix_xfer;
    logic pal_xfer;

    logic r_busy;
    logic r_out_valid;

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_busy || (adv && gen_last);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign pix_xfer   = in_xfer && (i_command == pes_pkg::CMD_PIXELS);
    assign pal_xfer   = in_xfer && (i_command == pes_pkg::CMD_PALETTE);

    // ---------------- frame position ----------------
    logic [GW-1:0]     r_col_group;
    logic [RW-1:0]     r_src_row;
    logic [ADDR_W-1:0] r_row_base;
    logic [SW_W-1:0]   row_step;
    logic [CW-1:0]     col_off;

    assign row_step = SW_W'(scale_eff) * SW_W'(r_stride);
    assign col_off  = CW'({r_col_group, {K_W{1'b0}}}) * CW'(scale_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_group <= '0;
            r_src_row   <= '0;
            r_row_base  <= '0;
        end else if (pix_xfer) begin
            if (r_col_group >= LAST_GROUP) begin
                r_col_group <= '0;
                if (r_src_row >= LAST_ROW) begin
                    r_src_row  <= '0;
                    r_row_base <= '0;
                end else begin
                    r_src_row  <= r_src_row + RW'(1);
                    r_row_base <= r_row_base + ADDR_W'(row_step);
                end
            end else begin
                r_col_group <= r_col_group + GW'(1);
            end
        end
    end

    // ---------------- write sequencer ----------------
    logic [pes_pkg::GROUP_W-1:0] r_group;
    logic [K_W-1:0]     r_k,   n_k;
    logic [SCALE_W-1:0] r_r,   n_r;
    logic [SCALE_W-1:0] r_c,   n_c;
    logic [ADDR_W-1:0]  r_pix_addr, n_pix_addr;  // row base + col * scale
    logic [ADDR_W-1:0]  r_row_off,  n_row_off;   // r * stride
    logic               n_busy;
    logic [ADDR_W-1:0]  gen_addr;
    logic [INDEX_W-1:0] gen_index;

    assign gen_last  = r_busy && (r_k == LAST_K) && (r_r == scale_max) && (r_c == scale_max);
    assign gen_addr  = r_pix_addr + r_row_off + ADDR_W'(r_c);
    assign gen_index = r_group[r_k*INDEX_W +: INDEX_W];

    always_comb begin
        n_busy     = r_busy;
        n_k        = r_k;
        n_r        = r_r;
        n_c        = r_c;
        n_pix_addr = r_pix_addr;
        n_row_off  = r_row_off;
        if (r_busy && adv) begin
            if (r_c != scale_max) begin
                n_c = r_c + SCALE_W'(1);
            end else begin
                n_c = '0;
                if (r_r != scale_max) begin
                    n_r       = r_r + SCALE_W'(1);
                    n_row_off = r_row_off + ADDR_W'(r_stride);
                end else begin
                    n_r       = '0;
                    n_row_off = '0;
                    if (r_k != LAST_K) begin
                        n_k        = r_k + K_W'(1);
                        n_pix_addr = r_pix_addr + ADDR_W'(scale_eff);
                    end else begin
                        n_busy = 1'b0;
                    end
                end
            end
        end
        if (pix_xfer) begin
            n_busy     = 1'b1;
            n_k        = '0;
            n_r        = '0;
            n_c        = '0;
            n_row_off  = '0;
            n_pix_addr = r_row_base + ADDR_W'(col_off);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_r        <= n_r;
        r_c        <= n_c;
        r_pix_addr <= n_pix_addr;
        r_row_off  <= n_row_off;
        if (pix_xfer) begin
            r_group <= i_pixel_group;
        end
    end

    // ---------------- palette ----------------
    logic [COLOR_W-1:0] pal_wdata;
    logic [COLOR_W-1:0] pal_rdata;
    logic               rd_en;
    logic [ENTRIES-1:0] r_entry_valid;
    logic               r_rd_valid;

    assign pal_wdata = pes_pkg::place_level(i_red_level,   r_red_shift)
                     | pes_pkg::place_level(i_green_level, r_green_shift)
                     | pes_pkg::place_level(i_blue_level,  r_blue_shift);
    assign rd_en     = adv && r_busy;

    pes_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_xfer),
        .i_waddr (i_entry_index),
        .i_wdata (pal_wdata),
        .i_re    (rd_en),
        .i_raddr (gen_index),
        .o_rdata (pal_rdata)
    );

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
        end else if (pal_xfer) begin
            r_entry_valid[i_entry_index] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_valid <= r_entry_valid[gen_index];
        end
    end

    // ---------------- read stage and output register ----------------
    logic               r_s1_valid;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic               r_s1_last;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= r_busy;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_addr   <= gen_addr;
            r_s1_last   <= gen_last;
            r_out_addr  <= r_s1_addr;
            r_out_last  <= r_s1_last;
            r_out_color <= r_rd_valid ? pal_rdata : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_address = r_out_addr;
    assign o_write_color   = r_out_color;
    assign o_last_of_item  = r_out_last;

endmodule

`default_nettype wire
